>>> hw/rtl/lrk_pkg.sv
`timescale 1ns / 1ps

package lrk_pkg;

   // Point word and field widths.
   localparam int WORD_BITS = 32;
   localparam int GAIN_BITS = 23;
   localparam int STEP_BITS = 17;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGMA = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RHO = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BETA = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP = 3'd3;

   // Register defaults: sigma 10, rho 28, beta about 8/3, step about 1/60.
   localparam logic [GAIN_BITS-1:0] SIGMA_RESET = 23'd655360;
   localparam logic [GAIN_BITS-1:0] RHO_RESET = 23'd1835008;
   localparam logic [GAIN_BITS-1:0] BETA_RESET = 23'd174763;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 17'd1092;

   // Division by six: multiply by ceil(2^34 / 6) and keep the bits from 34 up.
   localparam logic [WORD_BITS-1:0] RECIP6 = 32'hAAAA_AAAB;
   localparam int DIV6_SHIFT = WORD_BITS + 2;

   // Scratch memory layout: four slopes, the nudged point and two temporaries.
   localparam int K1_BASE = 0;
   localparam int K2_BASE = 3;
   localparam int K3_BASE = 6;
   localparam int K4_BASE = 9;
   localparam int SN_BASE = 12;
   localparam int T0_ADDR = 15;
   localparam int T1_ADDR = 16;
   localparam int RAM_DEPTH = 17;
   localparam int ADDR_BITS = $clog2(RAM_DEPTH);

   // Micro-program length.
   localparam int PC_BITS = 7;
   localparam logic [PC_BITS-1:0] LAST_PC = 7'd73;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV6
   } op_type;

   typedef enum logic [3:0] {
      SRC_RAM,
      SRC_POS_X,
      SRC_POS_Y,
      SRC_POS_Z,
      SRC_SIGMA,
      SRC_RHO,
      SRC_BETA,
      SRC_STEP,
      SRC_HALF
   } src_type;

   typedef enum logic [1:0] {
      DST_RAM,
      DST_POS_X,
      DST_POS_Y,
      DST_POS_Z
   } dst_type;

   typedef struct packed {
      src_type src;
      logic [ADDR_BITS-1:0] addr;
   } opnd_type;

   typedef struct packed {
      op_type op;
      opnd_type a;
      opnd_type b;
      dst_type dst;
      logic [ADDR_BITS-1:0] daddr;
   } uop_type;

   typedef struct packed {
      logic busy;
      logic wr_en;
      logic mul_load;
      uop_type uop;
   } seq_ctl_type;

   function automatic opnd_type ram_opnd(int addr);
      opnd_type o;
      o.src = SRC_RAM;
      o.addr = ADDR_BITS'(addr);
      return o;
   endfunction

   function automatic opnd_type src_opnd(src_type s);
      opnd_type o;
      o.src = s;
      o.addr = '0;
      return o;
   endfunction

   function automatic uop_type mk_uop(op_type op, opnd_type a, opnd_type b,
                                      dst_type dst, int daddr);
      uop_type u;
      u.op = op;
      u.a = a;
      u.b = b;
      u.dst = dst;
      u.daddr = ADDR_BITS'(daddr);
      return u;
   endfunction

   function automatic src_type pos_src(int j);
      src_type s;
      case (j)
         0: s = SRC_POS_X;
         1: s = SRC_POS_Y;
         default: s = SRC_POS_Z;
      endcase
      return s;
   endfunction

   function automatic dst_type pos_dst(int j);
      dst_type d;
      case (j)
         0: d = DST_POS_X;
         1: d = DST_POS_Y;
         default: d = DST_POS_Z;
      endcase
      return d;
   endfunction

   // Coordinate j of the slope input: the held point for k1, the nudged point otherwise.
   function automatic opnd_type state_opnd(int j, logic from_pos);
      opnd_type o;
      if (from_pos) begin
         o = src_opnd(pos_src(j));
      end else begin
         o = ram_opnd(SN_BASE + j);
      end
      return o;
   endfunction

   // Lorenz slope: dx = sigma*(y-x), dy = x*(rho-z) - y, dz = x*y - beta*z.
   function automatic uop_type slope_uop(int sub, logic from_pos, int kb);
      opnd_type sx;
      opnd_type sy;
      opnd_type sz;
      opnd_type t0;
      opnd_type t1;
      uop_type u;
      sx = state_opnd(0, from_pos);
      sy = state_opnd(1, from_pos);
      sz = state_opnd(2, from_pos);
      t0 = ram_opnd(T0_ADDR);
      t1 = ram_opnd(T1_ADDR);
      case (sub)
         0: u = mk_uop(OP_SUB, sy, sx, DST_RAM, T0_ADDR);
         1: u = mk_uop(OP_MUL, src_opnd(SRC_SIGMA), t0, DST_RAM, kb);
         2: u = mk_uop(OP_SUB, src_opnd(SRC_RHO), sz, DST_RAM, T0_ADDR);
         3: u = mk_uop(OP_MUL, sx, t0, DST_RAM, T0_ADDR);
         4: u = mk_uop(OP_SUB, t0, sy, DST_RAM, kb + 1);
         5: u = mk_uop(OP_MUL, sx, sy, DST_RAM, T0_ADDR);
         6: u = mk_uop(OP_MUL, src_opnd(SRC_BETA), sz, DST_RAM, T1_ADDR);
         default: u = mk_uop(OP_SUB, t0, t1, DST_RAM, kb + 2);
      endcase
      return u;
   endfunction

   // Nudged point: s' = s + k * h, one coordinate per two micro-operations.
   function automatic uop_type nudge_uop(int sub, int kb, src_type hs);
      int j;
      uop_type u;
      j = sub >> 1;
      if ((sub & 1) == 0) begin
         u = mk_uop(OP_MUL, ram_opnd(kb + j), src_opnd(hs), DST_RAM, T0_ADDR);
      end else begin
         u = mk_uop(OP_ADD, src_opnd(pos_src(j)), ram_opnd(T0_ADDR), DST_RAM, SN_BASE + j);
      end
      return u;
   endfunction

   // Weighted slope sum, division by six and the final update of coordinate c.
   function automatic uop_type blend_uop(int sub, int c);
      opnd_type t0;
      opnd_type t1;
      uop_type u;
      t0 = ram_opnd(T0_ADDR);
      t1 = ram_opnd(T1_ADDR);
      case (sub)
         0: u = mk_uop(OP_ADD, ram_opnd(K2_BASE + c), ram_opnd(K2_BASE + c), DST_RAM, T0_ADDR);
         1: u = mk_uop(OP_ADD, ram_opnd(K1_BASE + c), t0, DST_RAM, T0_ADDR);
         2: u = mk_uop(OP_ADD, ram_opnd(K3_BASE + c), ram_opnd(K3_BASE + c), DST_RAM, T1_ADDR);
         3: u = mk_uop(OP_ADD, t0, t1, DST_RAM, T0_ADDR);
         4: u = mk_uop(OP_ADD, t0, ram_opnd(K4_BASE + c), DST_RAM, T0_ADDR);
         5: u = mk_uop(OP_DIV6, t0, t0, DST_RAM, T0_ADDR);
         6: u = mk_uop(OP_MUL, t0, src_opnd(SRC_STEP), DST_RAM, T1_ADDR);
         default: u = mk_uop(OP_ADD, src_opnd(pos_src(c)), t1, pos_dst(c), 0);
      endcase
      return u;
   endfunction

   // Micro-program of one RK4 step.
   function automatic uop_type rk_uop(logic [PC_BITS-1:0] pc);
      int p;
      uop_type u;
      p = int'(pc);
      if (p < 8) begin
         u = slope_uop(p, 1'b1, K1_BASE);
      end else if (p < 14) begin
         u = nudge_uop(p - 8, K1_BASE, SRC_HALF);
      end else if (p < 22) begin
         u = slope_uop(p - 14, 1'b0, K2_BASE);
      end else if (p < 28) begin
         u = nudge_uop(p - 22, K2_BASE, SRC_HALF);
      end else if (p < 36) begin
         u = slope_uop(p - 28, 1'b0, K3_BASE);
      end else if (p < 42) begin
         u = nudge_uop(p - 36, K3_BASE, SRC_STEP);
      end else if (p < 50) begin
         u = slope_uop(p - 42, 1'b0, K4_BASE);
      end else begin
         u = blend_uop((p - 50) & 7, (p - 50) >> 3);
      end
      return u;
   endfunction

endpackage

>>> hw/rtl/lorenz_rk4_integrator_core.sv
`timescale 1ns / 1ps
// Advance item: once it is accepted, 74 micro-operations run on one shared add/multiply unit;
// an add or subtract reads and executes, a multiply or divide by six reads, executes and writes.
// Load item: the loaded point is reported as its result. One item at a time, so a new item is
// accepted once the previous result has entered the output register.
// Synchronous active-high reset sets each coordinate to one half and the registers to defaults.

module lorenz_rk4_integrator_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_func,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      req_load_x,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      req_load_y,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      req_load_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [lrk_pkg::WORD_BITS-1:0]      rsp_out_x,
   output logic signed [lrk_pkg::WORD_BITS-1:0]      rsp_out_y,
   output logic signed [lrk_pkg::WORD_BITS-1:0]      rsp_out_z,
   output logic                                      rsp_saturated,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [lrk_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [lrk_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);

   import lrk_pkg::*;

   localparam logic signed [WORD_BITS-1:0] POS_RESET = WORD_BITS'(1 << (FRAC_BITS - 1));

   logic                        req_accept;
   logic                        handoff;
   logic                        item_ff;
   seq_ctl_type                 ctl;

   logic [GAIN_BITS-1:0]        sigma_ff;
   logic [GAIN_BITS-1:0]        rho_ff;
   logic [GAIN_BITS-1:0]        beta_ff;
   logic [STEP_BITS-1:0]        step_ff;

   logic signed [WORD_BITS-1:0] pos_x_ff;
   logic signed [WORD_BITS-1:0] pos_y_ff;
   logic signed [WORD_BITS-1:0] pos_z_ff;
   logic signed [WORD_BITS-1:0] pos_x_in;
   logic signed [WORD_BITS-1:0] pos_y_in;
   logic signed [WORD_BITS-1:0] pos_z_in;
   logic                        sat_ff;
   logic                        sat_in;

   logic [WORD_BITS-1:0]        ram_rd_a;
   logic [WORD_BITS-1:0]        ram_rd_b;
   logic                        ram_we;
   logic signed [WORD_BITS-1:0] opnd_a;
   logic signed [WORD_BITS-1:0] opnd_b;
   logic signed [WORD_BITS-1:0] alu_result;
   logic                        alu_sat;

   logic                        rsp_valid_ff;
   logic signed [WORD_BITS-1:0] rsp_out_x_ff;
   logic signed [WORD_BITS-1:0] rsp_out_y_ff;
   logic signed [WORD_BITS-1:0] rsp_out_z_ff;
   logic                        rsp_saturated_ff;

   // Handshake: one item in the block until its result moves to the output register.
   assign req_accept = req_valid && !req_stall;
   assign req_stall = item_ff;
   assign handoff = item_ff && !ctl.busy && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= 1'b0;
      end else if (req_accept) begin
         item_ff <= 1'b1;
      end else if (handoff) begin
         item_ff <= 1'b0;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
         rho_ff <= RHO_RESET;
         beta_ff <= BETA_RESET;
         step_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIGMA: sigma_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_RHO: rho_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_BETA: beta_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_STEP: step_ff <= csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   lrk_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_accept && !req_func),
      .ctl   (ctl)
   );

   // Scratch memory for slopes, the nudged point and temporaries.
   assign ram_we = ctl.wr_en && (ctl.uop.dst == DST_RAM);

   lrk_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ctl.uop.daddr),
      .wr_data   (alu_result),
      .rd_addr_a (ctl.uop.a.addr),
      .rd_addr_b (ctl.uop.b.addr),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   // Operand selection for the shared unit.
   function automatic logic signed [WORD_BITS-1:0] pick(src_type src,
                                                        logic [WORD_BITS-1:0] ram_v);
      logic signed [WORD_BITS-1:0] v;
      unique case (src)
         SRC_POS_X: v = pos_x_ff;
         SRC_POS_Y: v = pos_y_ff;
         SRC_POS_Z: v = pos_z_ff;
         SRC_SIGMA: v = WORD_BITS'(sigma_ff);
         SRC_RHO: v = WORD_BITS'(rho_ff);
         SRC_BETA: v = WORD_BITS'(beta_ff);
         SRC_STEP: v = WORD_BITS'(step_ff);
         SRC_HALF: v = WORD_BITS'(step_ff >> 1);
         default: v = $signed(ram_v);
      endcase
      return v;
   endfunction

   always_comb begin
      opnd_a = pick(ctl.uop.a.src, ram_rd_a);
      opnd_b = pick(ctl.uop.b.src, ram_rd_b);
   end

   lrk_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock    (clock),
      .op       (ctl.uop.op),
      .mul_load (ctl.mul_load),
      .a        (opnd_a),
      .b        (opnd_b),
      .result   (alu_result),
      .sat      (alu_sat)
   );

   // Held point and saturation flag: loaded directly, or written by the final updates.
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      sat_in = sat_ff;
      if (req_accept && req_func) begin
         pos_x_in = req_load_x;
         pos_y_in = req_load_y;
         pos_z_in = req_load_z;
         sat_in = 1'b0;
      end else if (req_accept) begin
         sat_in = 1'b0;
      end else if (ctl.wr_en) begin
         sat_in = sat_ff || alu_sat;
         unique case (ctl.uop.dst)
            DST_POS_X: pos_x_in = alu_result;
            DST_POS_Y: pos_y_in = alu_result;
            DST_POS_Z: pos_z_in = alu_result;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= POS_RESET;
         pos_y_ff <= POS_RESET;
         pos_z_ff <= POS_RESET;
         sat_ff <= 1'b0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         sat_ff <= sat_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (handoff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (handoff) begin
         rsp_out_x_ff <= pos_x_ff;
         rsp_out_y_ff <= pos_y_ff;
         rsp_out_z_ff <= pos_z_ff;
         rsp_saturated_ff <= sat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_out_x_ff;
   assign rsp_out_y = rsp_out_y_ff;
   assign rsp_out_z = rsp_out_z_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // The sequencer only runs on behalf of an accepted item.
   a_busy_has_item: assert property (@(posedge clock) disable iff (reset)
      ctl.busy |-> item_ff)
      else $error("sequencer running without an item");

   // An advance item starts the sequencer on the next cycle.
   a_advance_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_func) |=> ctl.busy)
      else $error("advance item did not start the sequencer");

   // The point holds while neither a load nor a step is in progress.
   a_point_holds: assert property (@(posedge clock) disable iff (reset)
      (!ctl.busy && !req_accept) |=>
      ($stable(pos_x_ff) && $stable(pos_y_ff) && $stable(pos_z_ff)))
      else $error("point changed while idle");

   // A new result appears only from an item in the block.
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item_ff))
      else $error("result without an item");

   // Scratch writes happen only during a step.
   a_ram_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ctl.busy)
      else $error("scratch write outside a step");

endmodule

>>> hw/rtl/lrk_ram.sv
`timescale 1ns / 1ps

module lrk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> hw/rtl/lrk_alu.sv
`timescale 1ns / 1ps

module lrk_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  lrk_pkg::op_type                      op,
   input  logic                                 mul_load,
   input  logic signed [lrk_pkg::WORD_BITS-1:0] a,
   input  logic signed [lrk_pkg::WORD_BITS-1:0] b,
   output logic signed [lrk_pkg::WORD_BITS-1:0] result,
   output logic                                 sat
);

   import lrk_pkg::*;

   localparam int MW = WORD_BITS + 1;
   localparam int PW = 2 * MW;
   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

   logic [WORD_BITS-1:0]        mag;
   logic signed [MW-1:0]        mul_a;
   logic signed [MW-1:0]        mul_b;
   logic signed [PW-1:0]        prod_ff;
   logic signed [WORD_BITS:0]   sum;
   logic signed [PW-1:0]        shifted;
   logic [PW-WORD_BITS:0]       shifted_hi;
   logic signed [WORD_BITS-1:0] quot;

   // Multiplier operands: signed fixed-point product, or magnitude times 1/6.
   always_comb begin
      mag = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
      if (op == OP_DIV6) begin
         mul_a = $signed({1'b0, mag});
         mul_b = $signed({1'b0, RECIP6});
      end else begin
         mul_a = MW'(a);
         mul_b = MW'(b);
      end
   end

   // The shared multiplier, registered before any use of the product.
   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Saturating add and subtract, product scaling and division by six.
   always_comb begin
      sum = '0;
      shifted = prod_ff >>> FRAC_BITS;
      shifted_hi = shifted[PW-1:WORD_BITS-1];
      quot = $signed(prod_ff[DIV6_SHIFT +: WORD_BITS]);
      result = '0;
      sat = 1'b0;
      unique case (op) inside
         OP_ADD, OP_SUB: begin
            if (op == OP_ADD) begin
               sum = (WORD_BITS + 1)'(a) + (WORD_BITS + 1)'(b);
            end else begin
               sum = (WORD_BITS + 1)'(a) - (WORD_BITS + 1)'(b);
            end
            if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
               sat = 1'b1;
               result = sum[WORD_BITS] ? WMIN : WMAX;
            end else begin
               result = sum[WORD_BITS-1:0];
            end
         end
         OP_MUL: begin
            if (!((&shifted_hi) || !(|shifted_hi))) begin
               sat = 1'b1;
               result = shifted[PW-1] ? WMIN : WMAX;
            end else begin
               result = shifted[WORD_BITS-1:0];
            end
         end
         default: begin
            result = a[WORD_BITS-1] ? -quot : quot;
         end
      endcase
   end

endmodule

>>> hw/rtl/lrk_seq.sv
`timescale 1ns / 1ps

module lrk_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output lrk_pkg::seq_ctl_type ctl
);

   import lrk_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_WRITE
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [PC_BITS-1:0]   pc_ff;
   logic [PC_BITS-1:0]   pc_in;
   uop_type              uop;
   logic                 long_op;

   // Each micro-operation reads, then executes; multiplies and divides take a write cycle.
   always_comb begin
      uop = rk_uop(pc_ff);
      long_op = (uop.op == OP_MUL) || (uop.op == OP_DIV6);
      state_in = state_ff;
      pc_in = pc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
               pc_in = '0;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (long_op) begin
               state_in = ST_WRITE;
            end else if (pc_ff == LAST_PC) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
               pc_in = pc_ff + 1'b1;
            end
         end
         default: begin
            if (pc_ff == LAST_PC) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
               pc_in = pc_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
      end
   end

   // Control toward the datapath.
   always_comb begin
      ctl.busy = (state_ff != ST_IDLE);
      ctl.wr_en = ((state_ff == ST_EXEC) && !long_op) || (state_ff == ST_WRITE);
      ctl.mul_load = (state_ff == ST_EXEC);
      ctl.uop = uop;
   end

endmodule

>>> test/lorenz_rk4_checker.sv
`timescale 1ns / 1ps

// Codes shared by the stimulus and the checker.
package lorenz_tb_pkg;

   typedef enum logic {
      FUNC_ADVANCE = 1'b0,
      FUNC_LOAD = 1'b1
   } func_type;

   // Lowest register index that maps to no register.
   localparam logic [lrk_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd4;

endpackage

module lorenz_rk4_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_stall,
   input  logic                                      req_func,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      req_load_x,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      req_load_y,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      req_load_z,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      rsp_out_x,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      rsp_out_y,
   input  logic signed [lrk_pkg::WORD_BITS-1:0]      rsp_out_z,
   input  logic                                      rsp_saturated,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   input  logic [lrk_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [lrk_pkg::CSR_DATA_BITS-1:0]         csr_wdata,
   output int                                        mismatch_count,
   output int                                        pending_points
);

   import lrk_pkg::*;
   import lorenz_tb_pkg::*;

   localparam longint WORD_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
   localparam longint WORD_MIN = -WORD_MAX - 1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      longint x;
      longint y;
      longint z;
   } lorenz_vec_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] x;
      logic [WORD_BITS-1:0] y;
      logic [WORD_BITS-1:0] z;
      logic saturated;
   } point_result_type;

   // Mirror of the gains, the step and the held point.
   longint sigma_q;
   longint rho_q;
   longint beta_q;
   longint step_q;
   lorenz_vec_type held;
   bit sat_hit;
   point_result_type expected_points[$];

   initial begin
      mismatch_count = 0;
      pending_points = 0;
   end

   // Saturate to the signed word range and note that it happened.
   function automatic longint clip_word(longint v);
      if (v > WORD_MAX) begin
         sat_hit = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         sat_hit = 1'b1;
         return WORD_MIN;
      end
      return v;
   endfunction

   function automatic longint add_sat(longint a, longint b);
      return clip_word(a + b);
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      return clip_word(a - b);
   endfunction

   // The full product fits in 64 bits; the arithmetic shift rounds toward minus infinity.
   function automatic longint mul_q(longint a, longint b);
      return clip_word((a * b) >>> FRAC_BITS);
   endfunction

   // Lorenz derivative at one point.
   function automatic lorenz_vec_type lorenz_slope(lorenz_vec_type s);
      lorenz_vec_type d;
      d.x = mul_q(sigma_q, sub_sat(s.y, s.x));
      d.y = sub_sat(mul_q(s.x, sub_sat(rho_q, s.z)), s.y);
      d.z = sub_sat(mul_q(s.x, s.y), mul_q(beta_q, s.z));
      return d;
   endfunction

   // Point moved along a slope by a step.
   function automatic lorenz_vec_type nudge(lorenz_vec_type s, lorenz_vec_type d, longint h);
      lorenz_vec_type r;
      r.x = add_sat(s.x, mul_q(d.x, h));
      r.y = add_sat(s.y, mul_q(d.y, h));
      r.z = add_sat(s.z, mul_q(d.z, h));
      return r;
   endfunction

   // Weighted slope sum, summed left to right, then divided by six toward zero.
   function automatic longint rk_blend(longint k1, longint k2, longint k3, longint k4);
      longint acc;
      acc = add_sat(k1, add_sat(k2, k2));
      acc = add_sat(acc, add_sat(k3, k3));
      acc = add_sat(acc, k4);
      return acc / 6;
   endfunction

   // Apply one item to the held point and return the point that the block should report.
   function automatic point_result_type step_point(logic func, logic [WORD_BITS-1:0] lx,
                                                   logic [WORD_BITS-1:0] ly,
                                                   logic [WORD_BITS-1:0] lz);
      lorenz_vec_type k1;
      lorenz_vec_type k2;
      lorenz_vec_type k3;
      lorenz_vec_type k4;
      lorenz_vec_type kk;
      longint half;
      point_result_type r;
      sat_hit = 1'b0;
      if (func == FUNC_LOAD) begin
         held.x = clip_word(longint'(signed'(lx)));
         held.y = clip_word(longint'(signed'(ly)));
         held.z = clip_word(longint'(signed'(lz)));
      end else begin
         half = step_q >>> 1;
         k1 = lorenz_slope(held);
         k2 = lorenz_slope(nudge(held, k1, half));
         k3 = lorenz_slope(nudge(held, k2, half));
         k4 = lorenz_slope(nudge(held, k3, step_q));
         kk.x = rk_blend(k1.x, k2.x, k3.x, k4.x);
         kk.y = rk_blend(k1.y, k2.y, k3.y, k4.y);
         kk.z = rk_blend(k1.z, k2.z, k3.z, k4.z);
         held = nudge(held, kk, step_q);
      end
      r.x = held.x[WORD_BITS-1:0];
      r.y = held.y[WORD_BITS-1:0];
      r.z = held.z[WORD_BITS-1:0];
      r.saturated = sat_hit;
      return r;
   endfunction

   // Track register writes, predict each accepted item and check each accepted result.
   always @(posedge clock) begin
      point_result_type got;
      point_result_type want;
      if (reset) begin
         sigma_q = longint'(SIGMA_RESET);
         rho_q = longint'(RHO_RESET);
         beta_q = longint'(BETA_RESET);
         step_q = longint'(STEP_RESET);
         held.x = longint'(1) <<< (FRAC_BITS - 1);
         held.y = held.x;
         held.z = held.x;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIGMA: sigma_q = longint'(csr_wdata[GAIN_BITS-1:0]);
               CSR_RHO: rho_q = longint'(csr_wdata[GAIN_BITS-1:0]);
               CSR_BETA: beta_q = longint'(csr_wdata[GAIN_BITS-1:0]);
               CSR_STEP: step_q = longint'(csr_wdata[STEP_BITS-1:0]);
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            want = step_point(req_func, req_load_x, req_load_y, req_load_z);
            expected_points = {expected_points, want};
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated};
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result x=%h y=%h z=%h saturated=%b", $time,
                           got.x, got.y, got.z, got.saturated);
               end
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected x=%h y=%h z=%h saturated=%b", $time,
                              want.x, want.y, want.z, want.saturated);
                     $display("%0t: actual   x=%h y=%h z=%h saturated=%b", $time,
                              got.x, got.y, got.z, got.saturated);
                  end
               end
            end
         end
      end
      pending_points = expected_points.size();
   end

endmodule

>>> test/tb_lorenz_rk4_integrator_core.sv
`timescale 1ns / 1ps

module tb_lorenz_rk4_integrator_core;

   import lrk_pkg::*;
   import lorenz_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1030;
   localparam int LIMIT_CYCLES = 2000000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [WORD_BITS-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [WORD_BITS-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_BITS-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [CSR_DATA_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [CSR_DATA_BITS-1:0] GAIN_TOP = 32'd6553600;
   localparam logic [CSR_DATA_BITS-1:0] STEP_TOP = 32'd65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = FUNC_ADVANCE;
   logic signed [WORD_BITS-1:0] req_load_x = '0;
   logic signed [WORD_BITS-1:0] req_load_y = '0;
   logic signed [WORD_BITS-1:0] req_load_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WORD_BITS-1:0] rsp_out_x;
   logic signed [WORD_BITS-1:0] rsp_out_y;
   logic signed [WORD_BITS-1:0] rsp_out_z;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending_points;
   int send_idle_pct = 38;
   int recv_stall_pct = 50;
   int random_sent = 0;
   int cycle_count = 0;

   lorenz_rk4_integrator_core #(
      .FRAC_BITS(16)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_load_x(req_load_x),
      .req_load_y(req_load_y),
      .req_load_z(req_load_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   lorenz_rk4_checker #(
      .FRAC_BITS(16)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_load_x(req_load_x),
      .req_load_y(req_load_y),
      .req_load_z(req_load_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .pending_points(pending_points)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one item, maybe after an idle gap, and hold it until it is taken.
   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so the caller either sends again or drops valid at once.
   task automatic send_item(func_type f, logic [WORD_BITS-1:0] x, logic [WORD_BITS-1:0] y,
                            logic [WORD_BITS-1:0] z);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 4);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = f;
      req_load_x = x;
      req_load_y = y;
      req_load_z = z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic advance_point();
      send_item(FUNC_ADVANCE, $urandom, $urandom, $urandom);
   endtask

   // Drop valid and wait until every result has come back.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_points != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_gains(logic [CSR_DATA_BITS-1:0] sigma, logic [CSR_DATA_BITS-1:0] rho,
                              logic [CSR_DATA_BITS-1:0] beta, logic [CSR_DATA_BITS-1:0] step);
      write_reg(CSR_SIGMA, sigma);
      write_reg(CSR_RHO, rho);
      write_reg(CSR_BETA, beta);
      write_reg(CSR_STEP, step);
   endtask

   // A coordinate: mostly near the attractor, sometimes anywhere or at a corner.
   function automatic logic [WORD_BITS-1:0] pick_coord();
      logic [WORD_BITS-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: v = $urandom_range(0, 80 << 16) - (40 << 16);
         6, 7: v = $urandom;
         8: begin
            case ($urandom_range(5))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = '0;
               3: v = ALL_ONES;
               4: v = Q_ONE;
               default: v = 32'd1;
            endcase
         end
         default: v = $urandom_range(0, 512) - 256;
      endcase
      return v;
   endfunction

   // New gains and step for one random phase; the block is idle here.
   task automatic set_phase_config();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            write_gains($urandom_range(0, 20 << 16), $urandom_range(0, 50 << 16),
                        $urandom_range(0, 6 << 16), $urandom_range(1, 4096));
         end
         5, 6: begin
            write_gains($urandom_range(0, GAIN_TOP), $urandom_range(0, GAIN_TOP),
                        $urandom_range(0, GAIN_TOP), $urandom_range(1, STEP_TOP));
         end
         7: write_gains($urandom, $urandom, $urandom, $urandom);
         8: begin
            write_gains($urandom_range(1) ? GAIN_TOP : '0, $urandom_range(1) ? GAIN_TOP : '0,
                        $urandom_range(1) ? GAIN_TOP : '0,
                        $urandom_range(1) ? STEP_TOP : 32'd1);
         end
         default: write_gains(SIGMA_RESET, RHO_RESET, BETA_RESET, STEP_RESET);
      endcase
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_SPARE_LO + CSR_INDEX_BITS'($urandom_range(3)), $urandom);
      end
   endtask

   initial begin
      int phase_len;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: default point and gains, then loads at the word corners.
      advance_point();
      advance_point();
      advance_point();
      send_item(FUNC_LOAD, Q_ONE, Q_ONE, Q_ONE);
      advance_point();
      advance_point();
      send_item(FUNC_LOAD, Q_MAX, Q_MIN, '0);
      advance_point();
      send_item(FUNC_LOAD, Q_MIN, Q_MIN, Q_MIN);
      advance_point();
      send_item(FUNC_LOAD, Q_MAX, Q_MAX, Q_MAX);
      advance_point();
      send_item(FUNC_LOAD, ALL_ONES, 32'd1, 32'h0000_8000);
      wait_idle();

      // Gains above their range and a zero step: the point must not move.
      write_gains(ALL_ONES, '0, ALL_ONES, '0);
      advance_point();
      advance_point();
      wait_idle();

      // Smallest step, where the half step is zero.
      write_reg(CSR_STEP, 32'd1);
      advance_point();
      wait_idle();

      // Largest step the register holds.
      write_reg(CSR_STEP, ALL_ONES);
      send_item(FUNC_LOAD, Q_ONE, Q_ONE, Q_ONE);
      advance_point();
      advance_point();
      wait_idle();

      // Indexes past the register list are ignored.
      for (int i = 0; i < 4; i++) begin
         write_reg(CSR_SPARE_LO + CSR_INDEX_BITS'(i), $urandom);
      end
      write_gains(SIGMA_RESET, RHO_RESET, BETA_RESET, STEP_RESET);
      send_item(FUNC_LOAD, 32'h0002_0000, 32'hFFFD_0000, 32'h0019_0000);
      advance_point();
      advance_point();
      wait_idle();

      // Opposite gain extremes with the top step of the range.
      write_gains('0, GAIN_TOP, '0, STEP_TOP);
      advance_point();
      advance_point();

      // Random phases: fresh settings, a load, then mostly advances.
      while (random_sent < RANDOM_ITEMS) begin
         wait_idle();
         set_phase_config();
         phase_len = $urandom_range(10, 40);
         for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
               send_idle_pct = 38;
               recv_stall_pct = 50;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
               send_idle_pct = 50;
               recv_stall_pct = 38;
            end else begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            if (i == 0 || $urandom_range(99) < 12) begin
               send_item(FUNC_LOAD, pick_coord(), pick_coord(), pick_coord());
            end else begin
               advance_point();
            end
            random_sent++;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_points == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
